// File: hw/rtl/distance_ratio_consistency_check_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the distance ratio consistency check
// Immediate-implication and next-cycle-implication checks with a
// synchronous active-low reset as the disable condition.
// ----------------------------------------------------------------------------
`ifndef DISTANCE_RATIO_CONSISTENCY_CHECK_ASSERT_SVH
`define DISTANCE_RATIO_CONSISTENCY_CHECK_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DRCC_ASSERT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DRCC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/drcc_pkg.sv
// ----------------------------------------------------------------------------
// drcc_pkg
// Shared types and constants of the distance ratio consistency check.
// ----------------------------------------------------------------------------
`default_nettype none

package drcc_pkg;

  localparam int POINT_W   = 6;
  localparam int DIST_IN_W = 16;
  localparam int THR_W     = 17;
  localparam int TIDX_W    = 6;
  localparam int Q_SHIFT   = 16;
  localparam int POINT_LIM = 64;

  localparam logic [THR_W-1:0] THR_ONE   = 17'd65536;
  localparam logic [THR_W-1:0] THR_RESET = 17'd58982;

  localparam logic REQ_TABLE = 1'b0;
  localparam logic REQ_ELEM  = 1'b1;

  typedef struct packed {
    logic                 req_type;
    logic [POINT_W-1:0]   row_index;
    logic [POINT_W-1:0]   col_index;
    logic [DIST_IN_W-1:0] distance_value;
    logic [POINT_W-1:0]   first_point;
    logic [POINT_W-1:0]   second_point;
    logic                 last_element;
  } in_item_t;

  typedef struct packed {
    logic consistent;
    logic tuple_overflow;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              tbl_wr;
    logic              elem_wr;
    logic [TIDX_W-1:0] elem_idx;
    logic              clr_fail;
    logic              issue_row;
    logic              issue_col;
    logic [TIDX_W-1:0] rd_idx;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pipe_busy;
    logic fail;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/distance_ratio_consistency_check.sv
// ----------------------------------------------------------------------------
// distance_ratio_consistency_check
// Checks two point tuples for consistent pairwise distance ratios against a
// stored distance table.
// ----------------------------------------------------------------------------
// A table write or a non-final element pair is taken while idle, and the block
// stays ready for the next item. The final element pair of an n-element tuple
// (n capped at MAX_TUPLE) starts a check that walks all n*n ordered index
// pairs, one pair per cycle through the two read ports of the distance table,
// but held at the start of each row to fetch the row's tuple entry from the
// single-read-port tuple store. It then waits for the compare pipeline to
// drain and loads the result, after which the next item is taken. The result
// waits in its own register, so new items are accepted while it is still
// unread; a further result waits until it is taken. The threshold register
// may be written on any cycle the block is idle and is applied saturated at 1.0.
`default_nettype none

module distance_ratio_consistency_check #(
  parameter int MAX_POINTS = 64,
  parameter int MAX_TUPLE  = 16,
  parameter int DIST_WIDTH = 16
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire  drcc_pkg::in_item_t       in_data,
  output logic                           out_valid,
  input  wire                            out_ready,
  output drcc_pkg::out_item_t            out_data,
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire  [drcc_pkg::THR_W-1:0]     cfg_data
);

  drcc_pkg::dp_cmd_t  cmd;
  drcc_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;

  drcc_ctrl #(
    .MAX_TUPLE (MAX_TUPLE)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

  drcc_dpath #(
    .MAX_POINTS (MAX_POINTS),
    .MAX_TUPLE  (MAX_TUPLE),
    .DIST_WIDTH (DIST_WIDTH)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

`default_nettype wire

// File: hw/rtl/drcc_dpath.sv
// ----------------------------------------------------------------------------
// drcc_dpath
// Distance table, tuple store, threshold register and the pair-check pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

`include "distance_ratio_consistency_check_assert.svh"

module drcc_dpath #(
  parameter int MAX_POINTS = 64,
  parameter int MAX_TUPLE  = 16,
  parameter int DIST_WIDTH = 16
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_wr,
  input  wire  [drcc_pkg::THR_W-1:0]       cfg_data,
  input  wire  drcc_pkg::in_item_t         in_data,
  input  wire  drcc_pkg::dp_cmd_t          cmd,
  output drcc_pkg::dp_stat_t               stat
);

  localparam int PTW  = drcc_pkg::POINT_W;
  localparam int ROWS = (MAX_POINTS < drcc_pkg::POINT_LIM) ? MAX_POINTS : drcc_pkg::POINT_LIM;
  localparam int TBL_DEPTH = ROWS * ROWS;
  localparam int TAW  = $clog2(TBL_DEPTH);
  localparam int RCW  = PTW + 1;
  localparam int SW   = (DIST_WIDTH < drcc_pkg::DIST_IN_W) ? DIST_WIDTH : drcc_pkg::DIST_IN_W;
  localparam int TIW  = (MAX_TUPLE > 1) ? $clog2(MAX_TUPLE) : 1;
  localparam int PW   = drcc_pkg::THR_W + SW;
  localparam int EW   = 2 * PTW;

  function automatic logic [TAW-1:0] tbl_addr(input logic [PTW-1:0] row,
                                              input logic [PTW-1:0] col);
    logic in_rng;
    in_rng = ({1'b0, row} < RCW'(ROWS)) && ({1'b0, col} < RCW'(ROWS));
    tbl_addr = in_rng ? TAW'(row * ROWS + col) : '0;
  endfunction

  logic [SW-1:0]               tbl_mem [TBL_DEPTH];
  logic [EW-1:0]               tup_mem [MAX_TUPLE];

  logic [drcc_pkg::THR_W-1:0]  thr_r;
  logic [drcc_pkg::THR_W-1:0]  thr_sat;
  logic                        s1_vld_r;
  logic                        s1_row_r;
  logic                        s2_vld_r;
  logic                        s3_vld_r;
  logic                        fail_r;
  logic [EW-1:0]               tup_rd_r;
  logic [EW-1:0]               pi_r;
  logic [SW-1:0]               d1_r;
  logic [SW-1:0]               d2_r;
  logic                        ok1_r;
  logic                        ok2_r;
  logic [SW-1:0]               lo_r;
  logic [PW-1:0]               prod_r;

  logic [PTW-1:0]              pf;
  logic [PTW-1:0]              ps;
  logic [PTW-1:0]              tf;
  logic [PTW-1:0]              ts;
  logic                        ok1;
  logic                        ok2;
  logic                        wr_ok;
  logic [SW-1:0]               d1_v;
  logic [SW-1:0]               d2_v;
  logic [SW-1:0]               lo_v;
  logic [SW-1:0]               hi_v;
  logic [PW-1:0]               lo_sh;

  assign pf = pi_r[EW-1:PTW];
  assign ps = pi_r[PTW-1:0];
  assign tf = tup_rd_r[EW-1:PTW];
  assign ts = tup_rd_r[PTW-1:0];

  // A point index outside the table reads as distance zero.
  assign ok1 = ({1'b0, pf} < RCW'(ROWS)) && ({1'b0, tf} < RCW'(ROWS));
  assign ok2 = ({1'b0, ps} < RCW'(ROWS)) && ({1'b0, ts} < RCW'(ROWS));
  assign wr_ok = ({1'b0, in_data.row_index} < RCW'(ROWS)) &&
                 ({1'b0, in_data.col_index} < RCW'(ROWS));

  assign thr_sat = (thr_r > drcc_pkg::THR_ONE) ? drcc_pkg::THR_ONE : thr_r;

  always_comb begin
    d1_v  = ok1_r ? d1_r : '0;
    d2_v  = ok2_r ? d2_r : '0;
    lo_v  = (d1_v < d2_v) ? d1_v : d2_v;
    hi_v  = (d1_v < d2_v) ? d2_v : d1_v;
    lo_sh = PW'({lo_r, {drcc_pkg::Q_SHIFT{1'b0}}});
  end

  // Memories.
  always_ff @(posedge clk) begin
    if (cmd.tbl_wr && wr_ok) begin
      tbl_mem[tbl_addr(in_data.row_index, in_data.col_index)] <=
        in_data.distance_value[SW-1:0];
    end
    if (cmd.elem_wr) begin
      tup_mem[cmd.elem_idx[TIW-1:0]] <= {in_data.first_point, in_data.second_point};
    end
    tup_rd_r <= tup_mem[cmd.rd_idx[TIW-1:0]];
    d1_r     <= tbl_mem[tbl_addr(pf, tf)];
    d2_r     <= tbl_mem[tbl_addr(ps, ts)];
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    if (s1_vld_r && s1_row_r) begin
      pi_r <= tup_rd_r;
    end
    ok1_r  <= ok1;
    ok2_r  <= ok2;
    lo_r   <= lo_v;
    prod_r <= PW'(thr_sat) * PW'(hi_v);
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= drcc_pkg::THR_RESET;
      s1_vld_r <= 1'b0;
      s1_row_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      fail_r   <= 1'b0;
    end else begin
      if (cfg_wr) begin
        thr_r <= cfg_data;
      end
      s1_vld_r <= cmd.issue_row || cmd.issue_col;
      s1_row_r <= cmd.issue_row;
      s2_vld_r <= s1_vld_r && !s1_row_r;
      s3_vld_r <= s2_vld_r;
      if (cmd.clr_fail) begin
        fail_r <= 1'b0;
      end else if (s3_vld_r && (lo_sh < prod_r)) begin
        fail_r <= 1'b1;
      end
    end
  end

  assign stat.pipe_busy = s1_vld_r || s2_vld_r || s3_vld_r;
  assign stat.fail      = fail_r;

  `DRCC_ASSERT(a_clear_when_empty, clk, rst_n, cmd.clr_fail, !(s1_vld_r || s2_vld_r || s3_vld_r), "fail flag cleared while pairs are in flight")
  `DRCC_ASSERT(a_no_write_in_check, clk, rst_n, cmd.tbl_wr || cmd.elem_wr, !(s1_vld_r || s2_vld_r || s3_vld_r), "store written during a check")
  `DRCC_ASSERT_NEXT(a_fail_sticky, clk, rst_n, fail_r && !cmd.clr_fail, fail_r, "fail flag dropped without a clear")

endmodule

`default_nettype wire

// File: hw/rtl/drcc_ctrl.sv
// ----------------------------------------------------------------------------
// drcc_ctrl
// Controller: accepts items, counts tuple elements, sequences the pair
// check and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "distance_ratio_consistency_check_assert.svh"

module drcc_ctrl #(
  parameter int MAX_TUPLE = 16
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  output logic                       in_ready,
  input  wire  drcc_pkg::in_item_t   in_data,
  output logic                       out_valid,
  input  wire                        out_ready,
  output drcc_pkg::out_item_t        out_data,
  output drcc_pkg::dp_cmd_t          cmd,
  input  wire  drcc_pkg::dp_stat_t   stat
);

  localparam int CW = $clog2(MAX_TUPLE + 1);
  localparam int TI = drcc_pkg::TIDX_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROW,
    ST_COL,
    ST_DRAIN,
    ST_RESULT
  } state_t;

  state_t               state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [CW-1:0]        n_r, n_nxt;
  logic                 rovf_r, rovf_nxt;
  logic [CW-1:0]        i_r, i_nxt;
  logic [CW-1:0]        j_r, j_nxt;
  logic                 out_valid_r, out_valid_nxt;
  drcc_pkg::out_item_t  out_data_r, out_data_nxt;

  logic                 in_acc;
  logic                 has_room;
  logic [CW-1:0]        cnt_inc;
  logic                 ovf_any;

  assign has_room = count_r < CW'(MAX_TUPLE);
  assign cnt_inc  = has_room ? count_r + CW'(1) : count_r;
  assign ovf_any  = ovf_r || !has_room;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    n_nxt         = n_r;
    rovf_nxt      = rovf_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    cmd           = '0;
    in_ready      = (state_r == ST_IDLE);
    in_acc        = in_valid && in_ready;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data.req_type == drcc_pkg::REQ_TABLE) begin
            cmd.tbl_wr = 1'b1;
          end else begin
            // Pairs past the store depth are dropped and only flagged.
            cmd.elem_wr  = has_room;
            cmd.elem_idx = TI'(count_r);
            if (in_data.last_element) begin
              n_nxt        = cnt_inc;
              rovf_nxt     = ovf_any;
              count_nxt    = '0;
              ovf_nxt      = 1'b0;
              i_nxt        = '0;
              cmd.clr_fail = 1'b1;
              state_nxt    = ST_ROW;
            end else begin
              count_nxt = cnt_inc;
              ovf_nxt   = ovf_any;
            end
          end
        end
      end
      ST_ROW: begin
        cmd.issue_row = 1'b1;
        cmd.rd_idx    = TI'(i_r);
        j_nxt         = '0;
        state_nxt     = ST_COL;
      end
      ST_COL: begin
        cmd.issue_col = 1'b1;
        cmd.rd_idx    = TI'(j_r);
        if (j_r == n_r - CW'(1)) begin
          if (i_r == n_r - CW'(1)) begin
            state_nxt = ST_DRAIN;
          end else begin
            i_nxt     = i_r + CW'(1);
            state_nxt = ST_ROW;
          end
        end else begin
          j_nxt = j_r + CW'(1);
        end
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.consistent     = !stat.fail;
          out_data_nxt.tuple_overflow = rovf_r;
          state_nxt                   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      n_r         <= '0;
      rovf_r      <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      n_r         <= n_nxt;
      rovf_r      <= rovf_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `DRCC_ASSERT(a_read_in_tuple, clk, rst_n, cmd.issue_row || cmd.issue_col, cmd.rd_idx < n_r, "tuple read beyond the received elements")
  `DRCC_ASSERT(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(MAX_TUPLE), "element count above store depth")
  `DRCC_ASSERT(a_result_drained, clk, rst_n, state_r == ST_RESULT, !stat.pipe_busy, "result taken before the check drained")

endmodule

`default_nettype wire

// File: verif/distance_ratio_consistency_check_tb.sv
// ----------------------------------------------------------------------------
// distance_ratio_consistency_check_tb
// Fills the distance table and sends point tuples to the block. The expected
// verdict of each tuple is predicted from a local copy of the table, the tuple
// store and the threshold. Each result is compared with the oldest prediction,
// while both handshakes stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module distance_ratio_consistency_check_tb;

  localparam int MAX_POINTS  = 64;
  localparam int MAX_TUPLE   = 16;
  localparam int DIST_WIDTH  = 16;
  localparam int TOTAL_ITEMS = 550;
  localparam int QUIET_ITEMS = 70;
  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYC  = 8;

  typedef logic [drcc_pkg::POINT_W-1:0]   point_t;
  typedef logic [drcc_pkg::DIST_IN_W-1:0] dist_t;
  typedef logic [drcc_pkg::THR_W-1:0]     thr_t;

  typedef enum int {DIST_BAND, DIST_ANY, DIST_ZEROES, DIST_EXTREME} dist_style_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  drcc_pkg::in_item_t   in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  drcc_pkg::out_item_t  out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  thr_t                 cfg_data  = '0;

  // Local copy of the block's state.
  logic [DIST_WIDTH-1:0] dist_tab    [MAX_POINTS][MAX_POINTS];
  bit                    entry_known [MAX_POINTS][MAX_POINTS];
  point_t                tup_first   [MAX_TUPLE];
  point_t                tup_second  [MAX_TUPLE];
  int unsigned           elem_cnt  = 0;
  bit                    tuple_ovf = 1'b0;
  thr_t                  thr_model = drcc_pkg::THR_RESET;

  drcc_pkg::out_item_t pending_verdicts[$];
  int unsigned mismatch_cnt = 0;
  int unsigned items_sent   = 0;
  int unsigned idle_cycles  = 0;
  int unsigned ready_hold   = 0;
  bit          quiet_tail   = 1'b0;

  distance_ratio_consistency_check #(
    .MAX_POINTS(MAX_POINTS),
    .MAX_TUPLE (MAX_TUPLE),
    .DIST_WIDTH(DIST_WIDTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Verdict of the stored tuples: every ordered pair must satisfy
  // min * 1.0 >= threshold * max, with the threshold capped at 1.0.
  function automatic bit ratios_hold();
    logic [63:0] thr, d1, d2, lo, hi;
    thr = (thr_model > drcc_pkg::THR_ONE) ? 64'(drcc_pkg::THR_ONE) : 64'(thr_model);
    for (int i = 0; i < elem_cnt; i++) begin
      for (int j = 0; j < elem_cnt; j++) begin
        d1 = 64'(dist_tab[tup_first[i]][tup_first[j]]);
        d2 = 64'(dist_tab[tup_second[i]][tup_second[j]]);
        lo = (d1 < d2) ? d1 : d2;
        hi = (d1 < d2) ? d2 : d1;
        if ((lo << drcc_pkg::Q_SHIFT) < thr * hi) begin
          return 1'b0;
        end
      end
    end
    return 1'b1;
  endfunction

  function automatic void predict_item(drcc_pkg::in_item_t it);
    drcc_pkg::out_item_t verdict;
    if (it.req_type == drcc_pkg::REQ_TABLE) begin
      dist_tab[it.row_index][it.col_index] = it.distance_value;
      entry_known[it.row_index][it.col_index] = 1'b1;
      return;
    end
    if (elem_cnt < MAX_TUPLE) begin
      tup_first[elem_cnt]  = it.first_point;
      tup_second[elem_cnt] = it.second_point;
      elem_cnt++;
    end else begin
      tuple_ovf = 1'b1;
    end
    if (it.last_element) begin
      verdict.consistent     = ratios_hold();
      verdict.tuple_overflow = tuple_ovf;
      pending_verdicts = {pending_verdicts, verdict};
      elem_cnt  = 0;
      tuple_ovf = 1'b0;
    end
  endfunction

  function automatic drcc_pkg::in_item_t random_item();
    drcc_pkg::in_item_t it;
    it.req_type       = 1'($urandom_range(0, 1));
    it.row_index      = point_t'($urandom_range(0, 63));
    it.col_index      = point_t'($urandom_range(0, 63));
    it.distance_value = dist_t'($urandom_range(0, 65535));
    it.first_point    = point_t'($urandom_range(0, 63));
    it.second_point   = point_t'($urandom_range(0, 63));
    it.last_element   = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic void note_failure(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endfunction

  // The sender may idle for a burst before each item. Valid is held high
  // across back-to-back items and only lowered for a gap or a pause.
  task automatic send_item(drcc_pkg::in_item_t it);
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_data  <= it;
    in_valid <= 1'b1;
    predict_item(it);
    items_sent++;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_entry(point_t row, point_t col, dist_t value);
    drcc_pkg::in_item_t it;
    it = random_item();
    it.req_type       = drcc_pkg::REQ_TABLE;
    it.row_index      = row;
    it.col_index      = col;
    it.distance_value = value;
    send_item(it);
  endtask

  task automatic send_pair(point_t a, point_t b, bit last);
    drcc_pkg::in_item_t it;
    it = random_item();
    it.req_type     = drcc_pkg::REQ_ELEM;
    it.first_point  = a;
    it.second_point = b;
    it.last_element = last;
    send_item(it);
  endtask

  // Stops sending and waits until every predicted result has been taken.
  task automatic wait_verdicts_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic set_threshold(thr_t value);
    wait_verdicts_drained();
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    thr_model = value;
  endtask

  function automatic thr_t random_threshold();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return drcc_pkg::THR_ONE;
      2:       return '1;
      3:       return thr_t'($urandom_range(0, 131071));
      default: return thr_t'($urandom_range(50000, 65536));
    endcase
  endfunction

  // A small set of points is reused so that most tuples need few table writes.
  function automatic point_t pick_point(bit hot_only);
    if (!hot_only && $urandom_range(0, 3) == 0) begin
      return point_t'($urandom_range(0, 63));
    end
    case ($urandom_range(0, 7))
      0:       return 6'd0;
      1:       return 6'd1;
      2:       return 6'd2;
      3:       return 6'd21;
      4:       return 6'd42;
      5:       return 6'd61;
      6:       return 6'd62;
      default: return 6'd63;
    endcase
  endfunction

  function automatic dist_t gen_dist(dist_style_t style, int unsigned base);
    dist_t band;
    band = dist_t'(base + $urandom_range(0, base / 20));
    case (style)
      DIST_BAND:   return band;
      DIST_ANY:    return dist_t'($urandom_range(0, 65535));
      DIST_ZEROES: return ($urandom_range(0, 2) == 0) ? '0 : band;
      default: begin
        case ($urandom_range(0, 3))
          0:       return 16'd0;
          1:       return 16'd1;
          2:       return 16'd65534;
          default: return 16'd65535;
        endcase
      end
    endcase
  endfunction

  // Sends one tuple of len element pairs. Every table entry that the check
  // will read is written first, some of them in the middle of the tuple.
  task automatic run_tuple(int unsigned len, bit same_pts, dist_style_t style,
                           bit refresh, bit hot_only);
    point_t             pa[$];
    point_t             pb[$];
    point_t             wr_rows[$];
    point_t             wr_cols[$];
    bit                 planned[MAX_POINTS][MAX_POINTS];
    point_t             a, r, c;
    int unsigned        stored, nwr, base;
    base = $urandom_range(20, 60000);
    for (int i = 0; i < len; i++) begin
      a = pick_point(hot_only);
      pa = {pa, a};
      pb = {pb, same_pts ? a : pick_point(hot_only)};
    end
    stored = (len > MAX_TUPLE) ? MAX_TUPLE : len;
    for (int s = 0; s < 2; s++) begin
      for (int i = 0; i < stored; i++) begin
        for (int j = 0; j < stored; j++) begin
          r = s ? pb[i] : pa[i];
          c = s ? pb[j] : pa[j];
          if (!planned[r][c] && (refresh || !entry_known[r][c])) begin
            planned[r][c] = 1'b1;
            wr_rows = {wr_rows, r};
            wr_cols = {wr_cols, c};
          end
        end
      end
    end
    for (int k = 0; k < len; k++) begin
      if (k == len - 1) begin
        nwr = wr_rows.size();
      end else if ($urandom_range(0, 3) == 0) begin
        nwr = $urandom_range(0, wr_rows.size());
      end else begin
        nwr = 0;
      end
      repeat (nwr) write_entry(wr_rows.pop_front(), wr_cols.pop_front(),
                               gen_dist(style, base));
      send_pair(pa[k], pb[k], k == len - 1);
    end
  endtask

  task automatic random_tuple();
    int unsigned pick, len;
    dist_style_t style;
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      len = $urandom_range(1, 4);
    end else if (pick < 9) begin
      len = $urandom_range(5, 8);
    end else begin
      len = $urandom_range(9, 20);
    end
    style = ($urandom_range(0, 5) < 3) ? DIST_BAND : dist_style_t'($urandom_range(1, 3));
    run_tuple(len, $urandom_range(0, 3) == 0, style,
              len <= 4 && $urandom_range(0, 2) == 0, len > 4);
  endtask

  task automatic test_default_threshold();
    repeat (4) random_tuple();
  endtask

  task automatic test_directed_cases();
    // Both distances zero: the pair is ignored.
    write_entry(6'd5, 6'd5, 16'd0);
    write_entry(6'd9, 6'd9, 16'd0);
    send_pair(6'd5, 6'd9, 1'b1);
    // Exactly one distance zero fails; two equal full-scale distances pass.
    write_entry(6'd63, 6'd63, 16'hFFFF);
    send_pair(6'd63, 6'd5, 1'b1);
    write_entry(6'd0, 6'd0, 16'hFFFF);
    send_pair(6'd0, 6'd63, 1'b1);
    // Table writes arrive while the tuple is half received.
    send_pair(6'd0, 6'd63, 1'b0);
    write_entry(6'd0, 6'd63, 16'd40000);
    write_entry(6'd63, 6'd0, 16'd40000);
    send_pair(6'd63, 6'd0, 1'b1);
    send_pair(6'd63, 6'd63, 1'b1);
    // Just above and just below the default threshold.
    write_entry(6'd1, 6'd1, 16'd65535);
    write_entry(6'd2, 6'd2, 16'd58982);
    send_pair(6'd1, 6'd2, 1'b1);
    write_entry(6'd2, 6'd2, 16'd58981);
    send_pair(6'd2, 6'd1, 1'b1);
  endtask

  task automatic test_tuple_overflow();
    run_tuple(MAX_TUPLE, 1'b1, DIST_BAND, 1'b0, 1'b1);
    run_tuple(MAX_TUPLE + 1, 1'b0, DIST_BAND, 1'b0, 1'b1);
    run_tuple(MAX_TUPLE + 5, 1'b1, DIST_EXTREME, 1'b0, 1'b1);
    // The state must be clear again after an overflowed tuple.
    run_tuple(2, 1'b0, DIST_BAND, 1'b1, 1'b1);
  endtask

  task automatic test_threshold_sweep();
    thr_t sweep[$];
    sweep = '{17'd0, 17'd1, drcc_pkg::THR_RESET, 17'd65535, drcc_pkg::THR_ONE,
              17'd65537, 17'h1FFFF};
    sweep = {sweep, random_threshold()};
    foreach (sweep[k]) begin
      set_threshold(sweep[k]);
      repeat (3) random_tuple();
    end
  endtask

  task automatic test_random_traffic();
    int unsigned pick;
    while (items_sent < TOTAL_ITEMS) begin
      if (items_sent >= TOTAL_ITEMS - QUIET_ITEMS) begin
        quiet_tail = 1'b1;
      end
      pick = $urandom_range(0, 19);
      if (!quiet_tail && pick == 0) begin
        set_threshold(random_threshold());
      end else if (!quiet_tail && pick == 1) begin
        wait_verdicts_drained();
      end else if (pick < 5) begin
        repeat ($urandom_range(1, 3)) write_entry(point_t'($urandom_range(0, 63)),
                                                  point_t'($urandom_range(0, 63)),
                                                  dist_t'($urandom_range(0, 65535)));
      end
      random_tuple();
    end
  endtask

  // Result side: stalls at random, in bursts, until the quiet tail.
  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold = ready_hold - 1;
      out_ready <= 1'b0;
    end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      ready_hold = $urandom_range(0, 8);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    drcc_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        note_failure($sformatf("unexpected result consistent=%b overflow=%b",
                               out_data.consistent, out_data.tuple_overflow));
      end else begin
        want = pending_verdicts.pop_front();
        if (out_data.consistent !== want.consistent ||
            out_data.tuple_overflow !== want.tuple_overflow) begin
          note_failure($sformatf("expected consistent=%b overflow=%b, got %b %b",
                                 want.consistent, want.tuple_overflow,
                                 out_data.consistent, out_data.tuple_overflow));
        end
      end
    end
  end

  // Ends the run when no handshake of any kind completes for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_default_threshold();
    test_directed_cases();
    test_tuple_overflow();
    test_threshold_sweep();
    test_random_traffic();
    wait_verdicts_drained();
    repeat (40) @(posedge clk);
    if (mismatch_cnt == 0 && pending_verdicts.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
